### hw/rtl/gradient_edge_detector_3x3_assert.svh
// Assertion macros for the gradient edge detector.
// Used by the top level; empty when SYNTHESIS is defined.
`ifndef GRADIENT_EDGE_DETECTOR_3X3_ASSERT_SVH
`define GRADIENT_EDGE_DETECTOR_3X3_ASSERT_SVH
`ifndef SYNTHESIS
`define GED_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GED_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/gedge_pkg.sv
// Package of the gradient edge detector: size limits, payload types, register
// indexes, operator codes, reset values and kernel weights. No dependencies.
package gedge_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       start_of_frame;
    } t_pix_in;

    typedef struct packed {
        logic [12:0] magnitude;
        logic        edge_flag;
        logic [11:0] centre_row;
        logic [9:0]  centre_col;
        logic        last_of_frame;
    } t_res_out;

    localparam logic [1:0] CFG_WIDTH     = 2'd0;
    localparam logic [1:0] CFG_HEIGHT    = 2'd1;
    localparam logic [1:0] CFG_MODE      = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    localparam logic [1:0] MODE_SOBEL_Y  = 2'd0;
    localparam logic [1:0] MODE_SOBEL_X  = 2'd1;
    localparam logic [1:0] MODE_PREWITT  = 2'd2;
    localparam logic [1:0] MODE_SCHARR   = 2'd3;

    localparam logic [10:0] WIDTH_RST  = 11'd1024;
    localparam logic [12:0] HEIGHT_RST = 13'd1024;
    localparam logic [12:0] THRESH_RST = 13'd100;

    // Outer and middle kernel weights per operator.
    localparam logic signed [12:0] WT_SOBEL_0   = 13'sd1;
    localparam logic signed [12:0] WT_SOBEL_1   = 13'sd2;
    localparam logic signed [12:0] WT_PREWITT_0 = 13'sd1;
    localparam logic signed [12:0] WT_PREWITT_1 = 13'sd1;
    localparam logic signed [12:0] WT_SCHARR_0  = 13'sd3;
    localparam logic signed [12:0] WT_SCHARR_1  = 13'sd10;

endpackage

### hw/rtl/gradient_edge_detector_3x3.sv
// One pixel is in flight: after an interior pixel's request is taken, the unit passes
// through the line buffer read, gradient, square, sum, 13-step bit-serial square root
// and output states before the result is registered; a border pixel gives no result and
// frees the unit after the line buffer read. A new request is taken only once the unit
// is idle again, which waits while the previous result is held in a stalled output.
// Synchronous active-low reset clears counters, window, registers and handshake state;
// the line buffer memory is not cleared.
// Depends on gedge_pkg and gradient_edge_detector_3x3_assert.svh.
`include "gradient_edge_detector_3x3_assert.svh"
module gradient_edge_detector_3x3 #(
    parameter int MAX_WIDTH = gedge_pkg::MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gedge_pkg::t_pix_in i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gedge_pkg::t_res_out o_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [12:0]        i_cfg_data
);
    import gedge_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_GRAD = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_ROOT = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [1:0]  r_mode;
    logic [12:0] r_thresh;

    logic [2:0]  r_state;
    logic [CW-1:0] r_col, n_col, c0;
    logic [11:0] r_row, n_row, rw0;
    logic [CW-1:0] r_c;
    logic [11:0] r_r;
    logic [7:0]  r_pix;
    logic        r_last;

    logic [15:0] r_lbuf [MAX_WIDTH];
    logic [15:0] r_rd;
    logic [7:0]  r_win [3][3];

    logic [11:0] r_ax, r_ay;
    logic [23:0] r_sqx, r_sqy;
    logic [25:0] r_s, r_t2, r_rem, r_root, r_bit;

    logic        r_out_vld;
    t_res_out    r_out;

    logic [WW-1:0] w;
    logic [12:0]   h;
    logic          in_acc;
    logic          out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Effective frame size, saturated to the legal range.
    always_comb begin
        if (r_width < 11'd3) begin
            w = WW'(3);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_width);
        end
        if (r_height < 13'd3) begin
            h = 13'd3;
        end else if (r_height > 13'(MAX_HEIGHT)) begin
            h = 13'(MAX_HEIGHT);
        end else begin
            h = r_height;
        end
    end

    // Position of the arriving pixel and the counters after it.
    always_comb begin
        logic [CW-1:0] c_a;
        logic [12:0]   r_a;
        logic [WW:0]   c_inc;
        logic [12:0]   r_inc;
        c_a = i_in_data.start_of_frame ? '0 : r_col;
        r_a = i_in_data.start_of_frame ? 13'd0 : {1'b0, r_row};
        if (WW'(c_a) >= w) begin
            c_a = '0;
            r_a = r_a + 13'd1;
        end
        if (r_a >= h) begin
            r_a = 13'd0;
        end
        c0  = c_a;
        rw0 = r_a[11:0];
        c_inc = (WW + 1)'(c_a) + (WW + 1)'(1);
        r_inc = r_a + 13'd1;
        n_col = CW'(c_inc);
        n_row = rw0;
        if (c_inc >= (WW + 1)'(w)) begin
            n_col = '0;
            n_row = (r_inc >= h) ? 12'd0 : r_inc[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_mode   <= MODE_SOBEL_Y;
            r_thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:     r_width  <= i_cfg_data[10:0];
                CFG_HEIGHT:    r_height <= i_cfg_data;
                CFG_MODE:      r_mode   <= i_cfg_data[1:0];
                CFG_THRESHOLD: r_thresh <= i_cfg_data;
                default:       r_thresh <= r_thresh;
            endcase
        end
    end

    // Line buffers packed as {upper, middle}: read at request, written back in the next cycle.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd <= r_lbuf[c0];
        end
        if (r_state == S_RD) begin
            r_lbuf[r_c] <= {r_rd[7:0], r_pix};
        end
    end

    // Gradient terms from the window.
    logic signed [12:0] wt0, wt1, gx, gy;
    always_comb begin
        logic signed [12:0] dx [3];
        logic signed [12:0] dy [3];
        unique case (r_mode)
            MODE_PREWITT: begin wt0 = WT_PREWITT_0; wt1 = WT_PREWITT_1; end
            MODE_SCHARR:  begin wt0 = WT_SCHARR_0;  wt1 = WT_SCHARR_1;  end
            default:      begin wt0 = WT_SOBEL_0;   wt1 = WT_SOBEL_1;   end
        endcase
        for (int k = 0; k < 3; k++) begin
            dx[k] = $signed({5'd0, r_win[k][2]}) - $signed({5'd0, r_win[k][0]});
            dy[k] = $signed({5'd0, r_win[2][k]}) - $signed({5'd0, r_win[0][k]});
        end
        gx = 13'(wt0 * dx[0]) + 13'(wt1 * dx[1]) + 13'(wt0 * dx[2]);
        gy = 13'(wt0 * dy[0]) + 13'(wt1 * dy[1]) + 13'(wt0 * dy[2]);
    end

    logic [25:0] trial;
    assign trial = r_root + r_bit;

    logic [11:0] sel;
    assign sel = (r_mode == MODE_SOBEL_Y) ? r_ay : r_ax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_c    <= c0;
                        r_r    <= rw0;
                        r_pix  <= i_in_data.pixel_value;
                        r_last <= ({1'b0, rw0} == h - 13'd1) && (WW'(c0) == w - WW'(1));
                        r_col  <= n_col;
                        r_row  <= n_row;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[k][0] <= r_win[k][1];
                        r_win[k][1] <= r_win[k][2];
                    end
                    r_win[0][2] <= r_rd[15:8];
                    r_win[1][2] <= r_rd[7:0];
                    r_win[2][2] <= r_pix;
                    r_state <= (r_r >= 12'd2 && r_c >= CW'(2)) ? S_GRAD : S_IDLE;
                end
                S_GRAD: begin
                    r_ax <= 12'(gx < 0 ? -gx : gx);
                    r_ay <= 12'(gy < 0 ? -gy : gy);
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sqx <= 24'(r_ax) * 24'(r_ax);
                    r_sqy <= 24'(r_ay) * 24'(r_ay);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_s    <= 26'(r_sqx) + 26'(r_sqy);
                    r_rem  <= 26'(r_sqx) + 26'(r_sqy);
                    r_t2   <= 26'(r_thresh) * 26'(r_thresh);
                    r_root <= '0;
                    r_bit  <= 26'h1000000;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (r_rem >= trial) begin
                        r_rem  <= r_rem - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 26'd1) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register; the unit may start the next pixel while a result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            if (r_mode == MODE_SOBEL_Y || r_mode == MODE_SOBEL_X) begin
                r_out.magnitude <= {1'b0, sel};
                r_out.edge_flag <= {1'b0, sel} > r_thresh;
            end else begin
                r_out.magnitude <= r_root[12:0];
                r_out.edge_flag <= r_s > r_t2;
            end
            r_out.centre_row    <= r_r - 12'd1;
            r_out.centre_col    <= 10'(r_c - CW'(1));
            r_out.last_of_frame <= r_last;
        end
    end

    `GED_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, in_acc, r_state == S_RD)
    `GED_ASSERT_IMPLY(a_root_bit, i_clk, i_rst_n, r_state == S_ROOT, $onehot(r_bit))
    `GED_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_state == S_OUT && !out_free, r_state == S_OUT)

endmodule

### tb/tb.sv
// Testbench of gradient_edge_detector_3x3: small directed frames with hand-worked results,
// then random and extreme frames checked against a built-in gradient predictor. Depends on gedge_pkg.
`timescale 1ns / 100ps
module tb;
    import gedge_pkg::*;

    localparam int DRAIN_CYCLES = 25;

    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  pix [9];
        logic [12:0] mag;
        logic        flag;
    } t_frame_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_pix_in  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_res_out o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_WIDTH;
    logic [12:0] i_cfg_data = '0;

    // Predictor state.
    logic [10:0] img_w;
    logic [12:0] img_h;
    logic [1:0]  op_mode;
    logic [12:0] thresh;
    logic [7:0]  line_up [1024];
    logic [7:0]  line_mid [1024];
    logic [7:0]  win [3][3];
    int unsigned col_cnt, row_cnt;

    t_res_out expected_grad [$];
    int       n_sent = 0;
    bit       failed = 1'b0;

    gradient_edge_detector_3x3 dut (.*);

    always #10 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned isqrt(input int unsigned s);
        int unsigned r;
        r = 0;
        for (int b = 12; b >= 0; b--) begin
            if ((r | (1 << b)) * (r | (1 << b)) <= s) r = r | (1 << b);
        end
        return r;
    endfunction

    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Advances the predictor by one pixel; returns 1 with the result for an interior centre.
    function automatic bit compute_gradient(input t_pix_in p, output t_res_out res);
        int unsigned w, h, r, c, s;
        int gx, gy, w0, w1, wk;
        w = (img_w < 3) ? 3 : (img_w > 1024) ? 1024 : img_w;
        h = (img_h < 3) ? 3 : (img_h > 4096) ? 4096 : img_h;
        res = '0;
        if (p.start_of_frame) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        r = row_cnt;
        c = col_cnt;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = line_up[c];
        win[1][2] = line_mid[c];
        win[2][2] = p.pixel_value;
        line_up[c] = line_mid[c];
        line_mid[c] = p.pixel_value;
        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
        if (r < 2 || c < 2) return 1'b0;
        case (op_mode)
            MODE_PREWITT: begin w0 = 1; w1 = 1; end
            MODE_SCHARR:  begin w0 = 3; w1 = 10; end
            default:      begin w0 = 1; w1 = 2; end
        endcase
        gx = 0;
        gy = 0;
        for (int k = 0; k < 3; k++) begin
            wk = (k == 1) ? w1 : w0;
            gx += wk * (int'(win[k][2]) - int'(win[k][0]));
            gy += wk * (int'(win[2][k]) - int'(win[0][k]));
        end
        if (op_mode == MODE_SOBEL_Y || op_mode == MODE_SOBEL_X) begin
            s = iabs((op_mode == MODE_SOBEL_Y) ? gy : gx);
            res.magnitude = 13'(s);
            res.edge_flag = s > thresh;
        end else begin
            s = gx * gx + gy * gy;
            res.magnitude = 13'(isqrt(s));
            res.edge_flag = s > thresh * thresh;
        end
        res.centre_row = 12'(r - 1);
        res.centre_col = 10'(c - 1);
        res.last_of_frame = (r == h - 1) && (c == w - 1);
        return 1'b1;
    endfunction

    // Sender side: optional idle cycles, then hold the request until it is taken.
    // An override result, when given, replaces the predicted one.
    task automatic send_pixel(input logic [7:0] pix, input logic sof,
                              input bit use_typed = 0, input t_res_out typed = '0);
        t_pix_in  p;
        t_res_out res;
        int idle_pct;
        idle_pct = (n_sent < 600) ? 9 : (n_sent < 1200) ? 85 : 0;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        p.pixel_value = pix;
        p.start_of_frame = sof;
        i_in_data = p;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (compute_gradient(p, res)) expected_grad.push_back(use_typed ? typed : res);
        n_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_WIDTH:  img_w = val[10:0];
            CFG_HEIGHT: img_h = val;
            CFG_MODE:   op_mode = val[1:0];
            default:    thresh = val;
        endcase
    endtask

    // Waits for all outstanding results, then lets a border pixel still in flight finish.
    task automatic drain();
        while (expected_grad.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [7:0] gen_pix(input int style);
        case (style)
            0: return 8'($urandom_range(255));
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            default: return 8'($urandom_range(120, 136));
        endcase
    endfunction

    // A positive max_pix caps every frame of the phase at that many pixels.
    task automatic run_phase(input logic [12:0] w, input logic [12:0] h,
                             input logic [1:0] mode, input logic [12:0] thr, input int frames,
                             input int max_pix = 0);
        int weff, heff, npix, style;
        drain();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_THRESHOLD, thr);
        weff = (w[10:0] < 3) ? 3 : (w[10:0] > 1024) ? 1024 : w[10:0];
        heff = (h < 3) ? 3 : (h > 4096) ? 4096 : h;
        for (int f = 0; f < frames; f++) begin
            style = $urandom_range(2);
            npix = weff * heff;
            if (max_pix > 0 && npix > max_pix) npix = max_pix;
            // A few frames are cut short; the next one usually restarts with a start of frame.
            if ($urandom_range(99) < 4) npix = $urandom_range(1, npix);
            for (int i = 0; i < npix; i++) begin
                // The first frame after a size change always starts clean, so that no
                // result reads line buffer columns that were never written.
                send_pixel(gen_pix(style),
                           (i == 0) ? (f == 0 || $urandom_range(99) >= 5) :
                                      ($urandom_range(299) == 0));
            end
        end
    endtask

    // Receiver: random stall, check on every accepted result.
    initial begin
        t_res_out got, want;
        forever begin
            @(negedge i_clk);
            i_out_stall = $urandom_range(99) <
                          ((n_sent < 600) ? 85 : (n_sent < 1200) ? 9 : 0);
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (expected_grad.size() == 0) begin
                    $display("%t: unexpected result %p", $time, got);
                    failed = 1'b1;
                end else begin
                    want = expected_grad.pop_front();
                    if (got.magnitude !== want.magnitude)
                        $display("%t: magnitude expected %0d got %0d",
                                 $time, want.magnitude, got.magnitude);
                    if (got.edge_flag !== want.edge_flag)
                        $display("%t: edge_flag expected %0d got %0d",
                                 $time, want.edge_flag, got.edge_flag);
                    if (got.centre_row !== want.centre_row)
                        $display("%t: centre_row expected %0d got %0d",
                                 $time, want.centre_row, got.centre_row);
                    if (got.centre_col !== want.centre_col)
                        $display("%t: centre_col expected %0d got %0d",
                                 $time, want.centre_col, got.centre_col);
                    if (got.last_of_frame !== want.last_of_frame)
                        $display("%t: last_of_frame expected %0d got %0d",
                                 $time, want.last_of_frame, got.last_of_frame);
                    if (got !== want) failed = 1'b1;
                end
            end
        end
    end

    initial begin
        t_frame_row frame_tab [3];
        t_res_out   typed;
        // Single-window 3x3 frames with values that can be worked out by hand.
        frame_tab[0] = '{MODE_SOBEL_Y, '{0, 0, 0, 0, 0, 0, 255, 255, 255}, 13'd1020, 1'b1};
        frame_tab[1] = '{MODE_PREWITT, '{0, 0, 255, 0, 0, 255, 0, 0, 255}, 13'd765, 1'b1};
        frame_tab[2] = '{MODE_SCHARR, '{0, 0, 255, 0, 0, 255, 0, 0, 255}, 13'd4080, 1'b1};

        img_w = WIDTH_RST;
        img_h = HEIGHT_RST;
        op_mode = MODE_SOBEL_Y;
        thresh = THRESH_RST;
        for (int i = 0; i < 1024; i++) begin
            line_up[i] = '0;
            line_mid[i] = '0;
        end
        win = '{default: '0};
        col_cnt = 0;
        row_cnt = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(CFG_WIDTH, 13'd3);
        write_reg(CFG_HEIGHT, 13'd3);
        foreach (frame_tab[f]) begin
            drain();
            write_reg(CFG_MODE, frame_tab[f].mode);
            typed = '{magnitude: frame_tab[f].mag, edge_flag: frame_tab[f].flag,
                      centre_row: 12'd1, centre_col: 10'd1, last_of_frame: 1'b1};
            for (int i = 0; i < 9; i++)
                send_pixel(frame_tab[f].pix[i], i == 0, i == 8, typed);
        end

        while (n_sent < 1400) begin
            int tsel;
            logic [12:0] thr;
            tsel = $urandom_range(3);
            thr = (tsel == 0) ? 13'd0 : (tsel == 1) ? 13'd5771 :
                  (tsel == 2) ? 13'd8191 : 13'($urandom_range(1500));
            run_phase($urandom_range(9) == 0 ? 13'($urandom_range(2)) : 13'($urandom_range(3, 12)),
                      $urandom_range(9) == 0 ? 13'($urandom_range(2)) : 13'($urandom_range(3, 8)),
                      2'($urandom_range(3)), thr, $urandom_range(1, 4));
        end
        // Extremes: saturated and largest register values, on shortened frames.
        run_phase(13'd2047, 13'd3, MODE_SOBEL_X, 13'd0, 1, 40);
        run_phase(13'd0, 13'd8191, MODE_PREWITT, 13'd0, 1, 60);
        run_phase(13'd3, 13'd4096, MODE_SCHARR, 13'd5771, 1, 60);
        drain();

        if (!failed && expected_grad.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/gedge_pkg.sv
hw/rtl/gradient_edge_detector_3x3.sv
tb/tb.sv
